[sv/rne_pkg.sv]
`timescale 1ns / 1ps

package rne_pkg;

	// decade codes, units up to thousands
	localparam logic [1:0] DEC_UNITS     = 2'd0;
	localparam logic [1:0] DEC_TENS      = 2'd1;
	localparam logic [1:0] DEC_HUNDREDS  = 2'd2;
	localparam logic [1:0] DEC_THOUSANDS = 2'd3;

	// one nonzero decimal digit of the numeral, queued from front to back
	typedef struct packed {
		logic [3:0] digit;
		logic [1:0] decade;
		logic       last;
	} token_t;

endpackage

[sv/rne_front.sv]
`timescale 1ns / 1ps

module rne_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [11:0]     value,
	input  logic            push,
	output logic            full,
	output rne_pkg::token_t tok,
	output logic            tok_push,
	input  logic            tok_full
);
	import rne_pkg::*;

	logic        busy_q;
	logic [11:0] rem_q;
	logic [1:0]  dec_q;

	logic [9:0]  scale;
	logic [13:0] mult [10];
	logic [3:0]  digit;
	logic [11:0] rem_next;
	logic        advance;

	function automatic logic [9:0] dec_scale(input logic [1:0] dec);
		case (dec)
			DEC_UNITS:     return 10'd1;
			DEC_TENS:      return 10'd10;
			DEC_HUNDREDS:  return 10'd100;
			DEC_THOUSANDS: return 10'd1000;
			default:       return 10'd1;
		endcase
	endfunction

	// digit of the current decade: count of multiples of the scale not above rem
	always_comb begin
		scale   = dec_scale(dec_q);
		mult[0] = '0;
		for (int j = 1; j < 10; j++) begin
			mult[j] = 14'(j * scale);
		end
		digit = '0;
		for (int j = 1; j < 10; j++) begin
			if ({2'b0, rem_q} >= mult[j]) begin
				digit = 4'(j);
			end
		end
		rem_next = rem_q - mult[digit][11:0];
	end

	assign tok.digit  = digit;
	assign tok.decade = dec_q;
	assign tok.last   = (rem_next == '0);
	assign tok_push   = busy_q && (digit != '0) && !tok_full;
	assign advance    = busy_q && ((digit == '0) || !tok_full);
	assign full       = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= '0;
			dec_q  <= DEC_THOUSANDS;
		end else if (!busy_q) begin
			if (push && (value != '0)) begin
				busy_q <= 1'b1;
				rem_q  <= value;
				dec_q  <= DEC_THOUSANDS;
			end
		end else if (advance) begin
			rem_q <= rem_next;
			dec_q <= dec_q - 2'd1;
			if (rem_next == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_busy_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q != '0))
		else $error("front busy with nothing left to encode");
`endif

endmodule

[sv/rne_fifo.sv]
`timescale 1ns / 1ps

module rne_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  rne_pkg::token_t wr_data,
	input  logic            wr_en,
	output logic            full,
	output rne_pkg::token_t rd_data,
	input  logic            rd_en,
	output logic            empty
);
	import rne_pkg::*;

	token_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign rd_data = slot_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("token queue count out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full))
		else $error("token written into a full queue");
`endif

endmodule

[sv/rne_back.sv]
`timescale 1ns / 1ps

module rne_back (
	input  logic            clk,
	input  logic            arst_n,
	input  rne_pkg::token_t head,
	input  logic            head_valid,
	output logic            head_pop,
	output logic [6:0]      letter,
	output logic            last,
	output logic            empty,
	input  logic            pop
);
	import rne_pkg::*;

	localparam logic [1:0] SLOT_ONE  = 2'd0;
	localparam logic [1:0] SLOT_FIVE = 2'd1;
	localparam logic [1:0] SLOT_TEN  = 2'd2;

	// I V X L C D M
	localparam logic [6:0] LETTERS [7] = '{7'h49, 7'h56, 7'h58, 7'h4C, 7'h43, 7'h44, 7'h4D};

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [6:0] letter_q;
	logic       last_q;

	logic [2:0] len;
	logic [1:0] kind;
	logic [2:0] sym;
	logic       final_slot;
	logic       step;

	function automatic logic [2:0] digit_len(input token_t t);
		if (t.decade == DEC_THOUSANDS) begin
			return t.digit[2:0];
		end
		case (t.digit)
			4'd1, 4'd5:       return 3'd1;
			4'd2, 4'd4, 4'd6,
			4'd9:             return 3'd2;
			4'd3, 4'd7:       return 3'd3;
			4'd8:             return 3'd4;
			default:          return 3'd0;
		endcase
	endfunction

	function automatic logic [1:0] slot_kind(input token_t t, input logic [1:0] idx);
		if (t.decade == DEC_THOUSANDS) begin
			return SLOT_ONE;
		end
		case (t.digit)
			4'd4:       return (idx == 2'd0) ? SLOT_ONE : SLOT_FIVE;
			4'd5:       return SLOT_FIVE;
			4'd6, 4'd7,
			4'd8:       return (idx == 2'd0) ? SLOT_FIVE : SLOT_ONE;
			4'd9:       return (idx == 2'd0) ? SLOT_ONE : SLOT_TEN;
			default:    return SLOT_ONE;
		endcase
	endfunction

	always_comb begin
		len        = digit_len(head);
		kind       = slot_kind(head, idx_q);
		sym        = {head.decade, 1'b0} + {1'b0, kind};
		final_slot = ({1'b0, idx_q} == (len - 3'd1));
		step       = head_valid && (!out_valid_q || pop);
	end

	assign head_pop = step && final_slot;
	assign letter   = letter_q;
	assign last     = last_q;
	assign empty    = !out_valid_q;

	always_ff @(posedge clk) begin
		if (step) begin
			letter_q <= LETTERS[sym];
			last_q   <= head.last && final_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				idx_q <= final_slot ? 2'd0 : idx_q + 2'd1;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_idx_in_digit: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> ({1'b0, idx_q} < digit_len(head)))
		else $error("letter index beyond the digit's pattern");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && out_valid_q && !head_valid) |=> !out_valid_q)
		else $error("result kept after transfer with nothing queued");
`endif

endmodule

[sv/roman_numeral_encoder.sv]
`timescale 1ns / 1ps

// Roman numeral encoder.
// Input channel: value (0..3999) is transferred when push is high and full is
// low. Values 4000..4095 follow the same greedy rule (leading MMMM).
// Result channel: one ASCII letter per transfer; letter/last hold the oldest
// waiting result while empty is low, and pop takes it. last marks the final
// letter of a numeral. A value of zero yields no letters.
// The first letter passes through the front's remainder register, the digit
// queue and the output register; the front also steps past each leading zero
// decade first. The front splits a value into decimal digits, one decade per
// cycle while the digit queue is not full, and keeps full high until the last
// nonzero digit is queued. The back emits one letter per cycle from a
// two-entry digit queue while a digit is queued and the receiver is not
// stalling.
// A stalled receiver only holds the output register; the digit queue then
// fills and the front, and in turn push, waits.
// Reset clears the front, the queue and the output register; empty is high.
module roman_numeral_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [11:0] value,
	input  logic        push,
	output logic        full,
	output logic [6:0]  letter,
	output logic        last,
	output logic        empty,
	input  logic        pop
);
	import rne_pkg::*;

	token_t tok;
	token_t head;
	logic   tok_push;
	logic   tok_full;
	logic   tok_empty;
	logic   head_pop;

	rne_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.value    (value),
		.push     (push),
		.full     (full),
		.tok      (tok),
		.tok_push (tok_push),
		.tok_full (tok_full)
	);

	rne_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_data (tok),
		.wr_en   (tok_push),
		.full    (tok_full),
		.rd_data (head),
		.rd_en   (head_pop),
		.empty   (tok_empty)
	);

	rne_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!tok_empty),
		.head_pop   (head_pop),
		.letter     (letter),
		.last       (last),
		.empty      (empty),
		.pop        (pop)
	);

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && (value != '0)) |=> full)
		else $error("front not busy after taking a nonzero value");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

package roman_tb_pkg;

	// symbol weights and ASCII codes, I up to M
	localparam int unsigned SYM_WEIGHT [7] = '{1, 5, 10, 50, 100, 500, 1000};
	localparam byte         SYM_CHAR   [7] = '{"I", "V", "X", "L", "C", "D", "M"};
	localparam int          SYM_M      = 6;

	typedef struct {
		byte  chr;
		logic tail;
	} letter_due_t;

	class numeral_board;
		letter_due_t letters_due[$];
		int          errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return letters_due.size();
		endfunction

		// greedy spelling of one accepted value, queued letter by letter
		function void note_value(logic [11:0] v);
			int unsigned rest;
			int unsigned pair;
			int          p;
			int          s;
			int          sym_q[$];
			letter_due_t item;
			rest = v;
			for (p = SYM_M; p >= 0 && rest != 0; p--) begin
				while (rest >= SYM_WEIGHT[p]) begin
					sym_q = {sym_q, p};
					rest -= SYM_WEIGHT[p];
				end
				if (p > 0) begin
					// tens pair with the power of ten two below, fives with the one just below
					s = (p % 2 == 0) ? p - 2 : p - 1;
					pair = SYM_WEIGHT[p] - SYM_WEIGHT[s];
					if (rest >= pair) begin
						sym_q = {sym_q, s, p};
						rest -= pair;
					end
				end
			end
			foreach (sym_q[i]) begin
				item.chr  = SYM_CHAR[sym_q[i]];
				item.tail = (i == sym_q.size() - 1);
				letters_due = {letters_due, item};
			end
		endfunction

		function void check_letter(logic [6:0] chr, logic tail);
			letter_due_t want;
			if (letters_due.size() == 0) begin
				$error("unexpected letter transfer: letter %0d last %0b", chr, tail);
				errors++;
				return;
			end
			want = letters_due.pop_front();
			if ({1'b0, chr} !== want.chr) begin
				$error("letter: expected %0d (%s), got %0d", want.chr, want.chr, chr);
				errors++;
			end
			if (tail !== want.tail) begin
				$error("last: expected %0b, got %0b", want.tail, tail);
				errors++;
			end
		endfunction
	endclass

endpackage

module testbench;
	import roman_tb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 300;
	localparam int N_RANDOM    = 205;

	logic        clk;
	logic        arst_n = 1'b0;
	logic [11:0] value  = '0;
	logic        push   = 1'b0;
	logic        pop    = 1'b0;
	logic        full;
	logic [6:0]  letter;
	logic        last;
	logic        empty;

	numeral_board sb;
	bit           hold_pop = 1'b0;
	int           cycles   = 0;

	roman_numeral_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (value),
		.push   (push),
		.full   (full),
		.letter (letter),
		.last   (last),
		.empty  (empty),
		.pop    (pop)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_letter(letter, last);
	end

	// receiver: switches between randomly chosen stall patterns
	initial begin : receiver
		int mode;
		int span;
		int n;
		mode = 0;
		span = 0;
		n    = 0;
		forever begin
			@(negedge clk);
			if (hold_pop) begin
				hold_pop = 1'b0;
				pop <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 3);
					span = $urandom_range(20, 80);
				end
				span--;
				n++;
				case (mode)
					0: pop <= 1'b1;
					1: pop <= (n % 3 == 0);
					2: pop <= 1'($urandom_range(0, 1));
					default: begin
						if ($urandom_range(0, 11) == 0) begin
							pop <= 1'b0;
							repeat ($urandom_range(4, 14)) @(negedge clk);
						end else begin
							pop <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	task automatic send_value(logic [11:0] v);
		@(negedge clk);
		push  <= 1'b1;
		value <= v;
		do @(posedge clk); while (full);
		sb.note_value(v);
	endtask

	task automatic sender_gap(int n);
		repeat (n) begin
			@(negedge clk);
			push  <= 1'b0;
			value <= 12'($urandom_range(0, 4095));
		end
	endtask

	task automatic drain_wait();
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	function automatic logic [11:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 12'd0;
		else if (r < 15)
			return 12'($urandom_range(4000, 4095));
		else if (r < 35)
			return 12'($urandom_range(1, 49));
		else
			return 12'($urandom_range(1, 3999));
	endfunction

	initial begin : stimulus
		logic [11:0] directed_vals[$];
		int          sent;
		int          burst;
		bit          held;
		bit          drained;
		directed_vals = {12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40, 12'd49,
			12'd50, 12'd90, 12'd100, 12'd400, 12'd444, 12'd500, 12'd900, 12'd1000,
			12'd1994, 12'd2048, 12'd3888, 12'd3999, 12'd4000, 12'd4094, 12'd4095,
			12'd0, 12'd3};
		sb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_vals[i]) begin
			send_value(directed_vals[i]);
			if ($urandom_range(0, 2) == 0)
				sender_gap($urandom_range(1, 5));
		end

		sent    = 0;
		held    = 1'b0;
		drained = 1'b0;
		while (sent < N_RANDOM) begin
			if (!held && sent >= 80) begin
				// receiver holds off while the sender keeps going: block fills up
				hold_pop = 1'b1;
				held     = 1'b1;
				repeat (24) send_value(12'($urandom_range(1, 3999)));
				sent += 24;
			end else if (!drained && sent >= 150) begin
				sender_gap(1);
				drain_wait();
				drained = 1'b1;
			end
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				send_value(pick_value());
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				sender_gap($urandom_range(1, 6));
		end
		sender_gap(1);

		drain_wait();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
